/* rtl/core/ccb_pkg.sv */
// Shared types, character codes and helpers for the C comment blanker.
// Has no dependencies. The front, queue, back and top-level files all use it.
package ccb_pkg;

  // Character codes that the scanner looks for.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One-hot scanner modes.
  typedef enum logic [4:0] {
    MODE_CODE  = 5'b00001,
    MODE_STR   = 5'b00010,
    MODE_CHR   = 5'b00100,
    MODE_LINE  = 5'b01000,
    MODE_BLOCK = 5'b10000
  } ccb_mode_e;

  // Work record passed from the front to the back: one or two output bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;   // byte1 is sent as well
    logic       last;  // the record closes the text
  } ccb_rec_t;

  // Inside a comment, line breaks are kept and everything else is blanked.
  function automatic logic [7:0] keep_breaks(input logic [7:0] b);
    keep_breaks = (b == ChLf || b == ChCr) ? b : ChSpace;
  endfunction

endpackage

/* rtl/core/c_comment_blanker.sv */
// Channel   Handshake                Payload
// input     in_valid_i / in_stall_o  text_byte_i, end_of_text_i
// output    out_valid_o / out_stall_i out_byte_o, run_last_o, text_done_o
//
// One source byte is taken per cycle while the record queue has room. A byte
// gives zero, one or two output bytes; the output register sends one per
// cycle while out_stall_i is low, so a two-byte record holds the back end until both are sent.
// A record is written into a queue slot and then loaded into the output register.
// Reset (rst_ni, asynchronous, active low) clears the scanner, queue and output.
// Top level of the C comment blanker; depends on ccb_pkg, ccb_front, ccb_queue and ccb_back.
module c_comment_blanker import ccb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  logic     push, full, pop, empty;
  ccb_rec_t push_rec, pop_rec;

  // Scanner and classifier.
  ccb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push),
    .push_rec_o   (push_rec),
    .q_full_i     (full)
  );

  // Record queue between the two halves.
  ccb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (full),
    .pop_i     (pop),
    .pop_rec_o (pop_rec),
    .empty_o   (empty)
  );

  // Byte sender.
  ccb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (pop),
    .pop_rec_i  (pop_rec),
    .empty_i    (empty),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .text_done_o(text_done_o)
  );

endmodule

/* rtl/core/ccb_front.sv */
// Front end of the C comment blanker: accepts source bytes, tracks the lexical mode
// and turns each byte into a record of zero, one or two output bytes.
// Depends on ccb_pkg.
module ccb_front import ccb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output ccb_rec_t   push_rec_o,
  input  logic       q_full_i
);

  ccb_mode_e mode_q, mode_d;
  logic      esc_q, esc_d;
  logic      star_q, star_d;
  logic      held_q, held_d;
  logic      emit0, emit1;
  logic      accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Scanner: next state and the bytes that this input produces.
  always_comb begin
    mode_d = mode_q;
    esc_d  = esc_q;
    star_d = star_q;
    held_d = held_q;
    emit0  = 1'b0;
    emit1  = 1'b0;
    push_rec_o.byte0 = text_byte_i;
    push_rec_o.byte1 = text_byte_i;
    push_rec_o.last  = end_of_text_i;
    case (mode_q)
      MODE_STR, MODE_CHR: begin
        emit0 = 1'b1;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (text_byte_i == ChBackslash) begin
          esc_d = 1'b1;
        end else if ((mode_q == MODE_STR && text_byte_i == ChDquote) ||
                     (mode_q == MODE_CHR && text_byte_i == ChSquote)) begin
          mode_d = MODE_CODE;
        end
      end
      MODE_LINE: begin
        emit0 = 1'b1;
        if (text_byte_i == ChLf) begin
          mode_d = MODE_CODE;
        end else begin
          push_rec_o.byte0 = keep_breaks(text_byte_i);
        end
      end
      MODE_BLOCK: begin
        emit0 = 1'b1;
        if (star_q && text_byte_i == ChSlash) begin
          mode_d = MODE_CODE;
          star_d = 1'b0;
          push_rec_o.byte0 = ChSpace;
        end else begin
          star_d = (text_byte_i == ChStar);
          push_rec_o.byte0 = keep_breaks(text_byte_i);
        end
      end
      default: begin
        // Code mode, where a held slash is resolved first.
        mode_d = MODE_CODE;
        if (held_q && (text_byte_i == ChSlash || text_byte_i == ChStar)) begin
          held_d = 1'b0;
          emit0  = 1'b1;
          emit1  = 1'b1;
          push_rec_o.byte0 = ChSpace;
          push_rec_o.byte1 = ChSpace;
          if (text_byte_i == ChSlash) begin
            mode_d = MODE_LINE;
          end else begin
            mode_d = MODE_BLOCK;
            star_d = 1'b0;
          end
        end else begin
          // The held slash, if any, goes out ahead of this byte.
          held_d = 1'b0;
          if (held_q) begin
            emit0 = 1'b1;
            push_rec_o.byte0 = ChSlash;
          end
          if (text_byte_i == ChSlash && !end_of_text_i) begin
            held_d = 1'b1;
          end else begin
            if (held_q) begin
              emit1 = 1'b1;
            end else begin
              emit0 = 1'b1;
            end
            if (text_byte_i == ChDquote) begin
              mode_d = MODE_STR;
              esc_d  = 1'b0;
            end else if (text_byte_i == ChSquote) begin
              mode_d = MODE_CHR;
              esc_d  = 1'b0;
            end
          end
        end
      end
    endcase
    push_rec_o.two = emit1;
  end

  assign push_o = accept && emit0;

  // Scanner state; the end of a text returns it to the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      esc_q  <= 1'b0;
      star_q <= 1'b0;
      held_q <= 1'b0;
    end else if (accept) begin
      if (end_of_text_i) begin
        mode_q <= MODE_CODE;
        esc_q  <= 1'b0;
        star_q <= 1'b0;
        held_q <= 1'b0;
      end else begin
        mode_q <= mode_d;
        esc_q  <= esc_d;
        star_q <= star_d;
        held_q <= held_d;
      end
    end
  end

endmodule

/* rtl/core/ccb_queue.sv */
// Short record queue between the front and the back of the C comment blanker.
// Depends on ccb_pkg.
module ccb_queue import ccb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ccb_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output ccb_rec_t pop_rec_o,
  output logic     empty_o
);

  ccb_rec_t               slot_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = slot_q[rd_ptr_q];

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ccb_back.sv */
// Back end of the C comment blanker: takes records from the queue and sends
// their bytes one per transfer through an output register. Depends on ccb_pkg.
module ccb_back import ccb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  output logic       pop_o,
  input  ccb_rec_t   pop_rec_i,
  input  logic       empty_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, done_q;
  logic       pend_q;        // second byte of the current record still to go
  logic [7:0] pend_byte_q;
  logic       pend_last_q;
  logic       load;

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && !empty_i;

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && pop_rec_i.two;
      end
    end
  end

  // Output and pending payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        byte_q     <= pend_byte_q;
        run_last_q <= 1'b1;
        done_q     <= pend_last_q;
      end else begin
        byte_q      <= pop_rec_i.byte0;
        run_last_q  <= !pop_rec_i.two;
        done_q      <= pop_rec_i.last && !pop_rec_i.two;
        pend_byte_q <= pop_rec_i.byte1;
        pend_last_q <= pop_rec_i.last;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = run_last_q;
  assign text_done_o = done_q;

endmodule
